// ===== rtl/fwr_pkg.sv =====
// Shared constants, operation codes and cell control type for the removable queue.
package fwr_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MODE_W     = 2;
    localparam int POS_W      = 4;
    localparam int OUT_CNT_W  = 5;

    // Operation selected by an input transfer
    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ    = 2'd0,
        MODE_DEQ    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_PEEK   = 2'd3
    } mode_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             rm_en;
        logic [IDX_W-1:0] rm_idx;
    } cell_ctrl_t;

endpackage

// ===== rtl/fifo_with_remove_at_index_unit.sv =====
// An input transfer's result is registered and appears on the master side in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; every operation, including a removal that closes
// the gap, completes in a single shift step of the cell chain.
// A new item is taken while a finished result waits, as long as that result leaves.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result;
// the cell contents are not cleared and are never read before being written.
module fifo_with_remove_at_index_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: data_in [31:0], position [35:32], zero pad [39:36]
    input  logic [39:0] s_tdata,
    // tuser: mode [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: data_out [31:0], found [32], overflow [33], occupancy [38:34], is_empty [39]
    output logic [39:0] m_tdata
);

    localparam int DEPTH = fwr_pkg::DEPTH;
    localparam int DW    = fwr_pkg::DATA_WIDTH;
    localparam int IW    = fwr_pkg::IDX_W;
    localparam int CW    = fwr_pkg::CNT_W;

    fwr_pkg::mode_t                 mode;
    logic [DW-1:0]                  data_in;
    logic [fwr_pkg::POS_W-1:0]      position;
    logic                           s_accept;

    logic [CW-1:0]                  fill_count_reg;
    logic [CW-1:0]                  fill_count_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [DW-1:0]                  data_out_reg;
    logic [DW-1:0]                  data_out_next;
    logic                           found_reg;
    logic                           found_next;
    logic                           overflow_reg;
    logic                           overflow_next;
    logic [CW-1:0]                  occ_reg;

    fwr_pkg::cell_ctrl_t            ctrl;
    logic [IW-1:0]                  rd_idx;
    logic [DW-1:0]                  slot_q [DEPTH];
    logic                           is_full;
    logic                           is_nonempty;
    logic                           pos_hit;

    // Unpack the input transfer
    assign mode     = fwr_pkg::mode_t'(s_tuser);
    assign data_in  = s_tdata[DW-1:0];
    assign position = s_tdata[DW +: fwr_pkg::POS_W];

    // Accept whenever the output register is free or being emptied
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign is_full     = (fill_count_reg >= CW'(DEPTH));
    assign is_nonempty = (fill_count_reg != '0);
    assign pos_hit     = (CW'(position) < fill_count_reg);

    // Decode the operation into a chain command and the result fields
    always_comb begin
        ctrl            = '0;
        ctrl.wr_idx     = fill_count_reg[IW-1:0];
        ctrl.rm_idx     = '0;
        rd_idx          = '0;
        fill_count_next = fill_count_reg;
        found_next      = 1'b0;
        overflow_next   = 1'b0;
        unique case (mode)
            fwr_pkg::MODE_ENQ: begin
                if (is_full) begin
                    overflow_next = 1'b1;
                end else begin
                    ctrl.wr_en      = s_accept;
                    fill_count_next = fill_count_reg + CW'(1);
                end
            end
            fwr_pkg::MODE_DEQ: begin
                if (is_nonempty) begin
                    ctrl.rm_en      = s_accept;
                    found_next      = 1'b1;
                    fill_count_next = fill_count_reg - CW'(1);
                end
            end
            fwr_pkg::MODE_REMOVE: begin
                rd_idx      = position[IW-1:0];
                ctrl.rm_idx = position[IW-1:0];
                if (pos_hit) begin
                    ctrl.rm_en      = s_accept;
                    found_next      = 1'b1;
                    fill_count_next = fill_count_reg - CW'(1);
                end
            end
            fwr_pkg::MODE_PEEK: begin
                found_next = is_nonempty;
            end
            default: begin
                found_next = 1'b0;
            end
        endcase
        data_out_next = found_next ? slot_q[rd_idx] : '0;
    end

    // Row of cells, each fed by its upper neighbour; the top cell is fed zeros
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DW-1:0] upper;
        if (i == DEPTH - 1) begin : g_top
            assign upper = '0;
        end else begin : g_mid
            assign upper = slot_q[i+1];
        end
        fwr_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (IW'(i)),
            .wr_data    (data_in),
            .upper_data (upper),
            .slot_q     (slot_q[i])
        );
    end

    // Output valid: set on accept, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                fill_count_reg <= fill_count_next;
            end
        end
    end

    // Hold the result payload until the next accepted item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            data_out_reg <= data_out_next;
            found_reg    <= found_next;
            overflow_reg <= overflow_next;
            occ_reg      <= fill_count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(occ_reg == '0),
                       fwr_pkg::OUT_CNT_W'(occ_reg),
                       overflow_reg,
                       found_reg,
                       data_out_reg};

    // Occupancy never exceeds the capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CW'(DEPTH))
        else $error("fill count above capacity");

    // A pending result always reports the current occupancy
    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (occ_reg == fill_count_reg))
        else $error("reported occupancy differs from fill count");

    // A result never claims both a hit and a dropped append
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(found_reg && overflow_reg))
        else $error("found and overflow both set");

    // An append to a non-full queue grows it by one
    a_enq_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (mode == fwr_pkg::MODE_ENQ) && !is_full)
        |=> (fill_count_reg == $past(fill_count_reg) + CW'(1)))
        else $error("append did not advance fill count");

endmodule

// ===== rtl/fwr_cell.sv =====
// One storage cell of the queue chain: loads a new word or takes its neighbour's word.
module fwr_cell (
    input  logic                            aclk,
    input  fwr_pkg::cell_ctrl_t             ctrl,
    input  logic [fwr_pkg::IDX_W-1:0]       cell_idx,
    input  logic [fwr_pkg::DATA_WIDTH-1:0]  wr_data,
    input  logic [fwr_pkg::DATA_WIDTH-1:0]  upper_data,
    output logic [fwr_pkg::DATA_WIDTH-1:0]  slot_q
);

    logic [fwr_pkg::DATA_WIDTH-1:0] slot_reg;
    logic [fwr_pkg::DATA_WIDTH-1:0] slot_next;

    // Shift down when at or above the removed place, else load on a matching append
    always_comb begin
        slot_next = slot_reg;
        if (ctrl.rm_en && (cell_idx >= ctrl.rm_idx)) begin
            slot_next = upper_data;
        end else if (ctrl.wr_en && (cell_idx == ctrl.wr_idx)) begin
            slot_next = wr_data;
        end
    end

    // Payload only: no reset
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_q = slot_reg;

endmodule

// ===== dv/fwr_scoreboard.sv =====
// Scoreboard for the removable queue: predicts every result and checks it on the master side.
`timescale 1ns / 100ps
module fwr_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // tdata: data_in [31:0], position [35:32], zero pad [39:36]
    input  logic [39:0] s_tdata,
    // tuser: mode [1:0]
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // tdata: data_out [31:0], found [32], overflow [33], occupancy [38:34], is_empty [39]
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          awaited_count,
    output int          checked_count
);

    localparam int DW    = fwr_pkg::DATA_WIDTH;
    localparam int OCC_W = fwr_pkg::OUT_CNT_W;

    typedef struct packed {
        logic [DW-1:0]    word;
        logic             found;
        logic             overflow;
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
    } queue_reply_t;

    // Words held by the queue, head first
    logic [DW-1:0] held_words [$];
    queue_reply_t  awaited_replies [$];
    int            n_fail    = 0;
    int            n_checked = 0;

    // Apply one operation to the held words and return the reply it produces
    function automatic queue_reply_t apply_queue_op(input fwr_pkg::mode_t op,
                                                    input logic [DW-1:0] word_in,
                                                    input logic [fwr_pkg::POS_W-1:0] pos);
        queue_reply_t reply;
        reply = '0;
        case (op)
            fwr_pkg::MODE_ENQ: begin
                if (held_words.size() >= fwr_pkg::DEPTH) reply.overflow = 1'b1;
                else held_words.push_back(word_in);
            end
            fwr_pkg::MODE_DEQ: begin
                if (held_words.size() > 0) begin
                    reply.word  = held_words.pop_front();
                    reply.found = 1'b1;
                end
            end
            fwr_pkg::MODE_REMOVE: begin
                // a position past the last entry finds nothing
                if (int'(pos) < held_words.size()) begin
                    reply.word  = held_words[pos];
                    reply.found = 1'b1;
                    held_words.delete(int'(pos));
                end
            end
            default: begin
                if (held_words.size() > 0) begin
                    reply.word  = held_words[0];
                    reply.found = 1'b1;
                end
            end
        endcase
        reply.occupancy = OCC_W'(held_words.size());
        reply.is_empty  = (held_words.size() == 0);
        return reply;
    endfunction

    task automatic note_mismatch(input string field, input logic [DW-1:0] want,
                                 input logic [DW-1:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        n_fail++;
    endtask

    // Compare one result transfer, field by field
    task automatic check_reply(input queue_reply_t want, input logic [39:0] bus);
        queue_reply_t got;
        got.word      = bus[31:0];
        got.found     = bus[32];
        got.overflow  = bus[33];
        got.occupancy = bus[38:34];
        got.is_empty  = bus[39];
        if (got.word !== want.word) note_mismatch("data_out", want.word, got.word);
        if (got.found !== want.found)
            note_mismatch("found", DW'(want.found), DW'(got.found));
        if (got.overflow !== want.overflow)
            note_mismatch("overflow", DW'(want.overflow), DW'(got.overflow));
        if (got.occupancy !== want.occupancy)
            note_mismatch("occupancy", DW'(want.occupancy), DW'(got.occupancy));
        if (got.is_empty !== want.is_empty)
            note_mismatch("is_empty", DW'(want.is_empty), DW'(got.is_empty));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_words.delete();
            awaited_replies.delete();
        end else begin
            // check a result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    n_fail++;
                end else begin
                    check_reply(awaited_replies.pop_front(), m_tdata);
                end
                n_checked++;
            end
            // predict the reply for an accepted input transfer
            if (s_tvalid && s_tready)
                awaited_replies.push_back(apply_queue_op(fwr_pkg::mode_t'(s_tuser),
                                                         s_tdata[31:0], s_tdata[35:32]));
        end
        fail_count    <= n_fail;
        awaited_count <= awaited_replies.size();
        checked_count <= n_checked;
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the removable queue testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_ITEMS  = 1575;
    localparam int TAIL_CYCLES   = 5;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = fwr_pkg::MODE_ENQ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int fail_count;
    int awaited_count;
    int checked_count;
    int mode_tally [4];
    int hold_reqs   = 0;
    int hold_served = 0;
    bit rx_steady   = 1'b0;
    bit tx_steady   = 1'b0;

    fifo_with_remove_at_index_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fwr_scoreboard u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .checked_count (checked_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: random back-pressure, steady stretches and long hold-offs on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 11);
            end
        end
    end

    // Stop the run when nothing moves on either channel for too long
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Hold one item on the input channel until it is transferred
    task automatic offer_item(input fwr_pkg::mode_t op, input logic [31:0] word,
                              input logic [3:0] pos);
        int gap;
        gap = 0;
        if (!tx_steady)
            while ($urandom_range(99) < 11) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, pos, word};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mode_tally[int'(op)]++;
    endtask

    // Drop valid and wait until every predicted result has left the block
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_count != 0) @(posedge aclk);
    endtask

    // Phases lean towards filling, mixing, draining and removing in turn
    task automatic offer_random(input int phase);
        int             roll;
        int             enq_w;
        int             deq_w;
        int             rem_w;
        fwr_pkg::mode_t op;
        logic [31:0]    word;
        logic [3:0]     pos;
        case (phase)
            0:       begin enq_w = 70; deq_w = 10; rem_w = 10; end
            1:       begin enq_w = 40; deq_w = 20; rem_w = 25; end
            2:       begin enq_w = 15; deq_w = 35; rem_w = 35; end
            default: begin enq_w = 45; deq_w = 5;  rem_w = 40; end
        endcase
        roll = $urandom_range(99);
        if (roll < enq_w)                      op = fwr_pkg::MODE_ENQ;
        else if (roll < enq_w + deq_w)         op = fwr_pkg::MODE_DEQ;
        else if (roll < enq_w + deq_w + rem_w) op = fwr_pkg::MODE_REMOVE;
        else                                   op = fwr_pkg::MODE_PEEK;
        roll = $urandom_range(99);
        if (roll < 5)       word = '0;
        else if (roll < 10) word = '1;
        else                word = $urandom;
        pos = (phase == 2) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
        offer_item(op, word, pos);
    endtask

    initial begin : stimulus
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue: nothing to take or see
        offer_item(fwr_pkg::MODE_PEEK, 32'h1234_5678, 4'd0);
        offer_item(fwr_pkg::MODE_DEQ, 32'hFFFF_FFFF, 4'd15);
        offer_item(fwr_pkg::MODE_REMOVE, 32'h0, 4'd0);
        // Fill to the top, then one enqueue that overflows
        for (n = 0; n < fwr_pkg::DEPTH + 1; n++) begin
            if (n == 0)      offer_item(fwr_pkg::MODE_ENQ, 32'h0000_0000, 4'd0);
            else if (n == 1) offer_item(fwr_pkg::MODE_ENQ, 32'hFFFF_FFFF, 4'd15);
            else if (n == 2) offer_item(fwr_pkg::MODE_ENQ, 32'hA5A5_A5A5, 4'd0);
            else if (n == 3) offer_item(fwr_pkg::MODE_ENQ, 32'h5A5A_5A5A, 4'd15);
            else             offer_item(fwr_pkg::MODE_ENQ, $urandom, 4'($urandom_range(15)));
        end
        // Remove the last entry, miss past the end, remove the head, peek and dequeue
        offer_item(fwr_pkg::MODE_REMOVE, 32'h0, 4'd15);
        offer_item(fwr_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 4'd15);
        offer_item(fwr_pkg::MODE_REMOVE, 32'h0, 4'd0);
        offer_item(fwr_pkg::MODE_PEEK, 32'h0, 4'd0);
        offer_item(fwr_pkg::MODE_DEQ, 32'h0, 4'd0);
        drain_results();

        // Random traffic
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) begin
                tx_steady = 1'b1;
                rx_steady <= 1'b1;
            end
            if (n == 450 || n == 1300) hold_reqs <= hold_reqs + 1;
            if (n == 650) begin
                tx_steady = 1'b0;
                rx_steady <= 1'b0;
            end
            if (n == 1000) drain_results();
            offer_random((n / 200) % 4);
        end

        // Let every result arrive, then idle for TAIL_CYCLES to catch anything stray
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d items: %0d enqueue, %0d dequeue, %0d remove, %0d peek.",
                 mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
                 mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3]);
        $display("Checked %0d results through fill, overflow, drain and two long stalls.",
                 checked_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== fifo_with_remove_at_index_unit.f =====
rtl/fwr_pkg.sv
rtl/fwr_cell.sv
rtl/fifo_with_remove_at_index_unit.sv
dv/fwr_scoreboard.sv
dv/tb_top.sv
